// ----- hdl/rpeg_pkg.sv -----
// Package for the RMS and peak energy gate.
// Holds the fixed field widths, the score weights, the register indexes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package rpeg_pkg;

    // Default values of the top level parameters.
    localparam int DEF_MAX_DIM      = 4096;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Fixed widths of the accumulator and the result fields.
    localparam int SUM_BITS  = 43;
    localparam int OUT_W     = 16;
    localparam int RMS_W     = 16;
    localparam int RMS_BIT_W = 4;
    localparam int SQRT_T_W  = RMS_W + 1;
    localparam int THR_W     = 16;

    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    // Score weights in Q0.16: 0.65 for rms and 0.35 for peak.
    localparam logic [15:0] W_RMS  = 16'd42598;
    localparam logic [15:0] W_PEAK = 16'd22938;

    // Rounding of the Q16.16 score down to Q16.0.
    localparam int SCORE_SHIFT = 16;
    localparam int SCORE_ROUND = 32768;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GATE_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_THR  = 2'd1;

    localparam logic [THR_W-1:0] DEF_THR_RESET = 16'd1434;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV,
        ST_SQ_MUL,
        ST_SQ_CMP,
        ST_SC_RMS,
        ST_SC_PEAK,
        ST_SC_ADD,
        ST_FINISH
    } state_t;

endpackage

// ----- hdl/rms_peak_energy_gate.sv -----
// RMS and peak energy gate: top level with the sequencer, the shared multiplier
// and the bit-serial divider. Depends on rpeg_pkg.
// An element passes through accept, square and accumulate before ready returns.
// After the last element of a vector the result beat follows 45 divider steps,
// 16 root trials on the shared multiplier (multiply, then compare) and the score states.
// The result sits in an output register, so the next vector is taken while it waits.
// Reset (aresetn low, synchronous) clears the sums, the state and the output valid.
`timescale 1ns / 1ps

module rms_peak_energy_gate import rpeg_pkg::*; #(
    parameter int MAX_DIM      = DEF_MAX_DIM,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    // Element input channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    input  logic                          s_last,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_fire,
    output logic [OUT_W-1:0]              m_rms_value,
    output logic [OUT_W-1:0]              m_peak_value,
    output logic [OUT_W-1:0]              m_score
);

    localparam int MUL_W     = (SAMPLE_WIDTH > SQRT_T_W) ? SAMPLE_WIDTH : SQRT_T_W;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int CNT_W     = $clog2(MAX_DIM + 1);
    localparam int DIV_W     = SUM_BITS + 2;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int SUMX_W    = ((SUM_BITS > PROD_W) ? SUM_BITS : PROD_W) + 1;
    localparam int QX_W      = (DIV_W > PROD_W) ? DIV_W : PROD_W;
    localparam int PK_EXT_W  = (SAMPLE_WIDTH > OUT_W) ? SAMPLE_WIDTH : OUT_W;

    state_t state_reg, state_next;

    logic [THR_W-1:0]        stored_thr_reg;
    logic [THR_W-1:0]        def_thr_reg;

    logic [SAMPLE_WIDTH-1:0] mag_reg, mag_next;
    logic                    last_reg, last_next;
    logic [SUM_BITS-1:0]     sum_reg, sum_next;
    logic [SAMPLE_WIDTH-1:0] peak_reg, peak_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [DIV_W-1:0]        dq_reg, dq_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [RMS_W-1:0]        r_reg, r_next;
    logic [RMS_BIT_W-1:0]    bit_reg, bit_next;

    logic                    m_valid_reg, m_valid_next;
    logic                    fire_reg, fire_next;
    logic [OUT_W-1:0]        rms_out_reg, rms_out_next;
    logic [OUT_W-1:0]        peak_out_reg, peak_out_next;
    logic [OUT_W-1:0]        score_reg, score_next;

    // Shared multiplier operands and product.
    logic [MUL_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]       mul_p;

    logic [SAMPLE_WIDTH-1:0] s_mag;
    logic [SUMX_W-1:0]       sum_wide;
    logic [SUM_BITS-1:0]     sum_sat;
    logic [CNT_W:0]          rem_shift;
    logic [CNT_W:0]          cnt_ext;
    logic [RMS_W-1:0]        cand;
    logic [SQRT_T_W-1:0]     trial;
    logic [THR_W-1:0]        thr;
    logic [ACC_W:0]          acc_rnd;
    logic [ACC_W:0]          sc_wide;
    logic [PK_EXT_W-1:0]     peak_ext;
    logic                    out_free;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_fire       = fire_reg;
    assign m_rms_value  = rms_out_reg;
    assign m_peak_value = peak_out_reg;
    assign m_score      = score_reg;

    // Magnitude of the incoming sample; negative full scale maps to 2^(w-1).
    assign s_mag = s_sample[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(~s_sample + 1'b1)
                                            : SAMPLE_WIDTH'(s_sample);

    // Saturating add of the registered square into the sum of squares.
    assign sum_wide = SUMX_W'(sum_reg) + SUMX_W'(prod_reg);
    assign sum_sat  = (sum_wide > SUMX_W'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_BITS-1:0];

    // One restoring division step: bring down the next dividend bit.
    assign rem_shift = {rem_reg, dq_reg[DIV_W-1]};
    assign cnt_ext   = {1'b0, cnt_reg};

    // Root trial: candidate with the current bit set, tested as (2c-1)^2 <= 4*sum/count.
    assign cand  = r_reg | (RMS_W'(1) << bit_reg);
    assign trial = {cand, 1'b0} - SQRT_T_W'(1);

    // Active threshold and rounded score.
    assign thr     = (stored_thr_reg != '0) ? stored_thr_reg : def_thr_reg;
    assign acc_rnd = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(SCORE_ROUND);
    assign sc_wide = acc_rnd >> SCORE_SHIFT;

    assign peak_ext = PK_EXT_W'(peak_reg);
    assign out_free = !m_valid_reg || m_ready;

    // Shared multiplier.
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_thr_reg <= '0;
            def_thr_reg    <= DEF_THR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GATE_THR: stored_thr_reg <= cfg_wdata[THR_W-1:0];
                CFG_DEF_THR:  def_thr_reg    <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            peak_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            div_cnt_reg <= '0;
            bit_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            peak_reg    <= peak_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            div_cnt_reg <= div_cnt_next;
            bit_reg     <= bit_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        mag_reg      <= mag_next;
        last_reg     <= last_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        r_reg        <= r_next;
        fire_reg     <= fire_next;
        rms_out_reg  <= rms_out_next;
        peak_out_reg <= peak_out_next;
        score_reg    <= score_next;
    end

    // Sequencer: next state, operand selection and register updates.
    always_comb begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        last_next     = last_reg;
        sum_next      = sum_reg;
        peak_next     = peak_reg;
        cnt_next      = cnt_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;
        r_next        = r_reg;
        bit_next      = bit_reg;
        m_valid_next  = m_valid_reg;
        fire_next     = fire_reg;
        rms_out_next  = rms_out_reg;
        peak_out_next = peak_out_reg;
        score_next    = score_reg;
        mul_a         = MUL_W'(mag_reg);
        mul_b         = MUL_W'(mag_reg);

        // The result beat leaves when the sink takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mag_next   = s_mag;
                    last_next  = s_last;
                    state_next = ST_SQUARE;
                end
            end

            // Square the magnitude.
            ST_SQUARE: begin
                prod_next  = mul_p;
                state_next = ST_ACCUM;
            end

            // Fold the element into the vector state; start the division on the last one.
            ST_ACCUM: begin
                sum_next = sum_sat;
                if (mag_reg > peak_reg) begin
                    peak_next = mag_reg;
                end
                if (cnt_reg < CNT_W'(MAX_DIM)) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (last_reg) begin
                    dq_next      = {sum_sat, 2'b00};
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            // Bit-serial division of 4*sum by the count; quotient collects in dq.
            ST_DIV: begin
                if (rem_shift >= cnt_ext) begin
                    rem_next = CNT_W'(rem_shift - cnt_ext);
                    dq_next  = {dq_reg[DIV_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift[CNT_W-1:0];
                    dq_next  = {dq_reg[DIV_W-2:0], 1'b0};
                end
                if (div_cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    r_next     = '0;
                    bit_next   = RMS_BIT_W'(RMS_W - 1);
                    state_next = ST_SQ_MUL;
                end else begin
                    div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                end
            end

            // Square the trial value.
            ST_SQ_MUL: begin
                mul_a      = MUL_W'(trial);
                mul_b      = MUL_W'(trial);
                prod_next  = mul_p;
                state_next = ST_SQ_CMP;
            end

            // Keep the bit if the trial square stays within the quotient.
            ST_SQ_CMP: begin
                if (QX_W'(prod_reg) <= QX_W'(dq_reg)) begin
                    r_next = cand;
                end
                if (bit_reg == '0) begin
                    state_next = ST_SC_RMS;
                end else begin
                    bit_next   = bit_reg - RMS_BIT_W'(1);
                    state_next = ST_SQ_MUL;
                end
            end

            // Weighted rms term.
            ST_SC_RMS: begin
                mul_a      = MUL_W'(W_RMS);
                mul_b      = MUL_W'(r_reg);
                prod_next  = mul_p;
                state_next = ST_SC_PEAK;
            end

            // Weighted peak term.
            ST_SC_PEAK: begin
                acc_next   = ACC_W'(prod_reg);
                mul_a      = MUL_W'(W_PEAK);
                mul_b      = MUL_W'(peak_reg);
                prod_next  = mul_p;
                state_next = ST_SC_ADD;
            end

            ST_SC_ADD: begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = ST_FINISH;
            end

            // Load the result register once it is free, then clear for the next vector.
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    fire_next     = (acc_reg > ACC_W'({thr, 16'b0}));
                    rms_out_next  = r_reg;
                    peak_out_next = peak_ext[OUT_W-1:0];
                    score_next    = (sc_wide > (ACC_W + 1)'({OUT_W{1'b1}})) ? {OUT_W{1'b1}}
                                                                          : sc_wide[OUT_W-1:0];
                    sum_next      = '0;
                    peak_next     = '0;
                    cnt_next      = '0;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/rpeg_checker.sv -----
// Port-level checker for the RMS and peak energy gate, with its bind statement.
// Depends on rpeg_pkg and the rms_peak_energy_gate top level.
`timescale 1ns / 1ps

module rpeg_checker import rpeg_pkg::*; #(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_fire,
    input logic [OUT_W-1:0] m_rms_value,
    input logic [OUT_W-1:0] m_peak_value,
    input logic [OUT_W-1:0] m_score
);

    // Reset leaves no result beat pending.
    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Each element beat keeps the sequencer busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted beat");

    // A stalled result beat holds its payload.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fire) && $stable(m_rms_value)
            && $stable(m_peak_value) && $stable(m_score))
        else $error("stalled result beat changed");

    // The weights sum to one, so the score lies between the smaller and the larger
    // of rms and peak. With a saturated count the rms can exceed the peak.
    a_score_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (SAMPLE_WIDTH <= OUT_W) |->
            ((m_score >= m_rms_value) || (m_score >= m_peak_value)) &&
            ((m_score <= m_rms_value) || (m_score <= m_peak_value)))
        else $error("score outside rms and peak");

endmodule

bind rms_peak_energy_gate rpeg_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_rpeg_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_fire       (m_fire),
    .m_rms_value  (m_rms_value),
    .m_peak_value (m_peak_value),
    .m_score      (m_score)
);

// ----- test/rpeg_checker.sv -----
// Scoreboard for the RMS and peak energy gate: watches the register port and both channels,
// keeps its own running energy sums and checks every result beat field by field.
// Depends on rpeg_pkg for the port widths, register indexes and score weights.
`timescale 1ns / 1ps

module rpeg_scoreboard import rpeg_pkg::*; (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]              cfg_wdata,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic signed [DEF_SAMPLE_WIDTH-1:0] s_sample,
    input  logic                               s_last,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic                               m_fire,
    input  logic [OUT_W-1:0]                   m_rms_value,
    input  logic [OUT_W-1:0]                   m_peak_value,
    input  logic [OUT_W-1:0]                   m_score,
    output int                                 mismatches,
    output int                                 outstanding,
    output int                                 summaries_checked
);

    typedef struct packed {
        logic             fire;
        logic [OUT_W-1:0] rms;
        logic [OUT_W-1:0] peak;
        logic [OUT_W-1:0] score;
    } gate_summary_t;

    localparam longint unsigned SQ_SUM_CAP = 64'(SUM_MAX);

    // Shadow copy of the thresholds and of the vector being collected.
    logic [THR_W-1:0] shadow_gate_thr;
    logic [THR_W-1:0] default_thr;
    longint unsigned  sq_sum;
    logic [OUT_W-1:0] peak_mag;
    int               vec_len;
    gate_summary_t    expected_summaries[$];

    // Root of the mean rounded to nearest: the largest r with (2r-1)^2 * n <= 4 * sum,
    // found one bit at a time from the top.
    function automatic logic [RMS_W-1:0] nearest_rms(input longint unsigned sum_sq,
                                                     input longint unsigned n);
        logic [RMS_W-1:0] root;
        longint unsigned  trial;
        longint unsigned  odd;
        root = '0;
        for (int b = RMS_W - 1; b >= 0; b--) begin
            trial = 64'(root);
            trial[b] = 1'b1;
            odd = 2 * trial - 1;
            if (odd * odd * n <= (sum_sq << 2))
                root[b] = 1'b1;
        end
        return root;
    endfunction

    // Result of one closed vector under the threshold that is active now.
    function automatic gate_summary_t summarize_vector(input longint unsigned sum_sq,
                                                      input int n,
                                                      input logic [OUT_W-1:0] peak,
                                                      input logic [THR_W-1:0] thr);
        gate_summary_t   res;
        longint unsigned weighted;
        longint unsigned rounded;
        res.rms  = nearest_rms(sum_sq, longint'(n));
        res.peak = peak;
        weighted = 64'(W_RMS) * 64'(res.rms) + 64'(W_PEAK) * 64'(peak);
        rounded  = (weighted + 64'(SCORE_ROUND)) >> SCORE_SHIFT;
        res.score = (rounded > 64'hFFFF) ? 16'hFFFF : rounded[OUT_W-1:0];
        // The decision uses the unrounded sum, so rounding of score cannot flip it.
        res.fire = (weighted > (64'(thr) << SCORE_SHIFT));
        return res;
    endfunction

    task automatic check_field(input string field, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        gate_summary_t   want;
        int              smp_val;
        longint unsigned mag;
        longint unsigned sq;
        if (!aresetn) begin
            shadow_gate_thr   = '0;
            default_thr       = DEF_THR_RESET;
            sq_sum            = 0;
            peak_mag          = '0;
            vec_len           = 0;
            mismatches        = 0;
            summaries_checked = 0;
            expected_summaries.delete();
        end else begin
            // Result beat: compare with the oldest summary still owed.
            if (m_valid && m_ready) begin
                if (expected_summaries.size() == 0) begin
                    $error("Result beat with no vector pending: fire %0d rms %0d peak %0d score %0d",
                           m_fire, m_rms_value, m_peak_value, m_score);
                    mismatches++;
                end else begin
                    want = expected_summaries.pop_front();
                    check_field("fire", want.fire, m_fire);
                    check_field("rms_value", want.rms, m_rms_value);
                    check_field("peak_value", want.peak, m_peak_value);
                    check_field("score", want.score, m_score);
                    summaries_checked++;
                end
            end

            // Register writes; a spare index changes nothing.
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_GATE_THR: shadow_gate_thr = cfg_wdata;
                    CFG_DEF_THR:  default_thr = cfg_wdata;
                    default: ;
                endcase
            end

            // Element beat: fold it into the running sums and close the vector on last.
            if (s_valid && s_ready) begin
                smp_val = int'(s_sample);
                mag = (smp_val < 0) ? longint'(-smp_val) : longint'(smp_val);
                sq = mag * mag;
                sq_sum = (sq > SQ_SUM_CAP - sq_sum) ? SQ_SUM_CAP : sq_sum + sq;
                if (mag > peak_mag)
                    peak_mag = mag[OUT_W-1:0];
                if (vec_len < DEF_MAX_DIM)
                    vec_len++;
                if (s_last) begin
                    want = summarize_vector(sq_sum, vec_len, peak_mag,
                        (shadow_gate_thr != '0) ? shadow_gate_thr : default_thr);
                    expected_summaries = {expected_summaries, want};
                    sq_sum     = 0;
                    peak_mag   = '0;
                    vec_len    = 0;
                end
            end
        end
        outstanding = expected_summaries.size();
    end

endmodule

// ----- test/tb.sv -----
// Top of the RMS and peak energy gate testbench: clock, reset, threshold writes,
// element stimulus with random gaps and result back-pressure, and the final verdict.
// Depends on rpeg_pkg, rms_peak_energy_gate and rpeg_scoreboard.
`timescale 1ns / 1ps

module tb;
    import rpeg_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 150;
    localparam int ITEM_TARGET  = 1850;
    localparam int DIRECTED_CNT = 16;
    localparam int NUM_PHASES   = 6;
    localparam int MAX_GAP      = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic signed [DEF_SAMPLE_WIDTH-1:0] FULL_POS = 16'sh7FFF;
    localparam logic signed [DEF_SAMPLE_WIDTH-1:0] FULL_NEG = 16'sh8000;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]               cfg_index = '0;
    logic [CFG_DATA_W-1:0]              cfg_wdata = '0;
    logic                               s_valid   = 1'b0;
    logic                               s_ready;
    logic signed [DEF_SAMPLE_WIDTH-1:0] s_sample  = '0;
    logic                               s_last    = 1'b0;
    logic                               m_valid;
    logic                               m_ready   = 1'b0;
    logic                               m_fire;
    logic [OUT_W-1:0]                   m_rms_value;
    logic [OUT_W-1:0]                   m_peak_value;
    logic [OUT_W-1:0]                   m_score;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int cycle_count    = 0;
    int beats_sent     = 0;
    int vectors_sent   = 0;
    int settings_used  = 1;
    int mismatches;
    int outstanding;
    int summaries_checked;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    rms_peak_energy_gate dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_fire       (m_fire),
        .m_rms_value  (m_rms_value),
        .m_peak_value (m_peak_value),
        .m_score      (m_score)
    );

    rpeg_scoreboard checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample          (s_sample),
        .s_last            (s_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_fire            (m_fire),
        .m_rms_value       (m_rms_value),
        .m_peak_value      (m_peak_value),
        .m_score           (m_score),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .summaries_checked (summaries_checked)
    );

    // Result back-pressure: stall at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, outstanding);
            $display("Regression FAIL");
            $finish;
        end
    end

    // One element beat, after a random gap when the sender is idling.
    task automatic send_beat(input logic signed [DEF_SAMPLE_WIDTH-1:0] smp, input logic lst);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        s_last   <= lst;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        beats_sent++;
    endtask

    // A vector of random elements limited to a signed magnitude of mag_bits bits,
    // with an occasional full-scale element mixed in.
    task automatic send_vector(input int len, input int mag_bits);
        logic signed [DEF_SAMPLE_WIDTH-1:0] smp;
        for (int k = 0; k < len; k++) begin
            smp = DEF_SAMPLE_WIDTH'($urandom);
            smp = smp >>> (DEF_SAMPLE_WIDTH - mag_bits);
            if ($urandom_range(31) == 0)
                smp = $urandom_range(1) ? FULL_POS : FULL_NEG;
            send_beat(smp, k == len - 1);
        end
        vectors_sent++;
    endtask

    // Mostly short vectors, some medium and a few long ones.
    task automatic run_random(input int items);
        int first;
        int pick;
        int len;
        first = beats_sent;
        while (beats_sent - first < items) begin
            pick = $urandom_range(99);
            if (pick < 80)
                len = $urandom_range(1, 12);
            else if (pick < 95)
                len = $urandom_range(13, 64);
            else
                len = $urandom_range(65, 300);
            send_vector(len, int'($urandom_range(1, DEF_SAMPLE_WIDTH)));
        end
    endtask

    // Drop valid, let every owed result arrive, then give the pipeline time to go quiet.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Both thresholds, followed by a write to a spare index that must be ignored.
    task automatic set_thresholds(input logic [THR_W-1:0] gate_val,
                                  input logic [THR_W-1:0] dflt_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_GATE_THR;
        cfg_wdata <= gate_val;
        @(posedge aclk);
        cfg_index <= CFG_DEF_THR;
        cfg_wdata <= dflt_val;
        @(posedge aclk);
        cfg_index <= $urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset thresholds, so the default of 1434 is active. A single element x
        // gives a weighted sum of exactly x, so 1434 sits on the threshold and must not fire.
        send_beat(16'sd1434, 1'b1);
        send_beat(16'sd1435, 1'b1);
        send_beat(16'sd1433, 1'b1);
        send_beat(-16'sd1434, 1'b1);
        send_beat(16'sd0, 1'b1);
        send_beat(FULL_NEG, 1'b1);
        send_beat(FULL_POS, 1'b1);
        send_beat(-16'sd1, 1'b1);
        send_beat(16'sd1, 1'b1);
        send_beat(FULL_POS, 1'b0);
        send_beat(FULL_NEG, 1'b0);
        send_beat(16'sh5555, 1'b1);
        send_beat(16'shAAAA, 1'b0);
        send_beat(16'sh5555, 1'b0);
        send_beat(16'sd0, 1'b0);
        send_beat(-16'sd1, 1'b1);
        vectors_sent += 11;
        settle();

        // Random phases, each under its own thresholds and idling pattern.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    src_idle_pct = 0;  sink_stall_pct = 0;
                    set_thresholds(16'd0, 16'd0);
                end
                1: begin
                    src_idle_pct = 61; sink_stall_pct = 0;
                    set_thresholds(16'hFFFF, THR_W'($urandom_range(200, 30000)));
                end
                2: begin
                    src_idle_pct = 0;  sink_stall_pct = 61;
                    set_thresholds(16'd1, 16'hFFFF);
                end
                3: begin
                    src_idle_pct = 11; sink_stall_pct = 11;
                    set_thresholds(THR_W'($urandom_range(200, 30000)),
                                   THR_W'($urandom_range(200, 30000)));
                end
                4: begin
                    src_idle_pct = 61; sink_stall_pct = 0;
                    set_thresholds(16'd0, 16'hFFFF);
                end
                default: begin
                    src_idle_pct = 0;  sink_stall_pct = 61;
                    set_thresholds(THR_W'($urandom_range(200, 30000)), 16'd0);
                end
            endcase
            run_random((ITEM_TARGET - DIRECTED_CNT) / NUM_PHASES);
            settle();
        end

        $display("Checked %0d results from %0d vectors (%0d element beats) under %0d threshold settings.",
                 summaries_checked, vectors_sent, beats_sent, settings_used);
        $display("Covered threshold ties, full-scale elements, and sender and receiver stalls.");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
